>>> design/aimd_pkg.sv
package aimd_pkg;

	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned QUO_W   = 26;  // 2^31 / 33 fits in 26 bits
	localparam int unsigned MET_W   = 28;  // metric range is well inside 28 bits signed

	localparam logic [LEVEL_W-1:0] LEVEL_MIN = 16'd33;
	localparam logic [MET_W-1:0]   ONE_Q16   = 28'd65536;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_CAPACITY  = 3'd0;
	localparam logic [IDX_W-1:0] REG_BETA_LOW  = 3'd1;
	localparam logic [IDX_W-1:0] REG_BETA_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAMMA     = 3'd3;
	localparam logic [IDX_W-1:0] REG_FLOOR     = 3'd4;
	localparam logic [IDX_W-1:0] REG_CEILING   = 3'd5;

	typedef enum logic [1:0] {
		MODE_DECREASE = 2'd0,
		MODE_HOLD     = 2'd1,
		MODE_INCREASE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_METRIC,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> design/aimd_level_if.sv
interface aimd_level_if;
	logic        valid;
	logic        ready;
	logic [15:0] level;

	modport source (output valid, output level, input ready);
	modport sink   (input valid, input level, output ready);
endinterface

>>> design/aimd_result_if.sv
interface aimd_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] rate;
	logic [1:0]  mode;

	modport source (output valid, output rate, output mode, input ready);
	modport sink   (input valid, input rate, input mode, output ready);
endinterface

>>> design/aimd_div.sv
// Restoring divider for 2^31 / divisor, one quotient bit a cycle.
module aimd_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [aimd_pkg::LEVEL_W-1:0]    divisor,
	output logic [aimd_pkg::QUO_W-1:0]      quotient,
	output aimd_pkg::div_status_t           status
);

	localparam int unsigned REM_W = aimd_pkg::LEVEL_W + 1;
	localparam int unsigned CNT_W = $clog2(aimd_pkg::QUO_W + 1);

	logic [REM_W-1:0]             rem_q;
	logic [aimd_pkg::QUO_W-1:0]   quo_q;
	logic [aimd_pkg::LEVEL_W-1:0] div_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [REM_W-1:0] shifted;
	logic [REM_W-1:0] diff;
	logic             fits;

	assign shifted = {rem_q[REM_W-2:0], 1'b0};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(aimd_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the divisor is at least 33, so the upper quotient bits are zero and the
	// partial remainder after them is 2^31 >> QUO_W = 32
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= REM_W'(32);
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff : shifted;
			quo_q <= {quo_q[aimd_pkg::QUO_W-2:0], fits};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> design/aimd_sampling_rate_fsm_top.sv
// Channel  Role    Payload                 Handshake
// sample   sink    level[15:0] Q1.15       valid/ready
// result   source  rate[15:0], mode[1:0]   valid/ready
// cfg      write   cfg_index[2:0], data32  cfg_we, no stall
//
// The first level after reset goes from accept straight to decide; every
// later level passes accept, a divider load, the bit-serial divider steps for
// the reciprocal plus its done flag, metric and decide. sample.ready is high
// only while idle.
// A finished word waits in the result register; the next level is taken
// meanwhile and holds in the decide step until the result slot is free.
// arst_n clears the sequencer, block state, configuration and result valid flag.
module aimd_sampling_rate_fsm_top #(
	parameter int unsigned RATE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	aimd_level_if.sink                    sample,
	aimd_result_if.source                 result,
	input  logic                          cfg_we,
	input  logic [aimd_pkg::IDX_W-1:0]    cfg_index,
	input  logic [aimd_pkg::CFG_W-1:0]    cfg_data
);

	// compare width: room for rate + 1 and for the 16-bit ceiling and floor
	localparam int unsigned CW = ((RATE_WIDTH > 16) ? RATE_WIDTH : 16) + 1;
	localparam logic [CW-1:0] RATE_MAX = CW'({RATE_WIDTH{1'b1}});

	// configuration registers
	logic [15:0]        capacity_q;
	logic signed [31:0] beta_low_q;
	logic signed [31:0] beta_high_q;
	logic [15:0]        gamma_q;
	logic [15:0]        floor_q;
	logic [15:0]        ceiling_q;

	// block state
	logic [15:0]            prev_q;
	logic                   has_prev_q;
	aimd_pkg::mode_t        mode_q;
	logic [RATE_WIDTH-1:0]  rate_q;

	// sequencer and working registers
	aimd_pkg::state_t       state_q, state_d;
	logic [15:0]            lvl_q;
	logic                   first_q;
	logic                   inf_q;
	logic signed [32:0]     prod_q;
	logic signed [aimd_pkg::MET_W-1:0] metric_q;

	// result word
	logic                   res_valid_q;
	logic [15:0]            res_rate_q;
	aimd_pkg::mode_t        res_mode_q;

	logic                   accept;
	logic                   slot_free;
	logic                   div_start;
	logic                   commit;
	logic [15:0]            lvl_clamped;
	logic [aimd_pkg::QUO_W-1:0] recip;
	aimd_pkg::div_status_t  div_st;

	logic signed [16:0]     diff;
	logic signed [aimd_pkg::MET_W-1:0] term;
	logic signed [31:0]     metric_ext;
	logic [CW-1:0]          rc, r_inc, r_next, r_fin;
	aimd_pkg::mode_t        mode_next;

	assign lvl_clamped = (sample.level < aimd_pkg::LEVEL_MIN) ? aimd_pkg::LEVEL_MIN
		: sample.level;
	assign accept    = sample.valid && sample.ready;
	assign slot_free = !res_valid_q || result.ready;

	aimd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (lvl_q),
		.quotient (recip),
		.status   (div_st)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			aimd_pkg::ST_IDLE: begin
				if (accept) state_d = has_prev_q ? aimd_pkg::ST_DIV : aimd_pkg::ST_DECIDE;
			end
			aimd_pkg::ST_DIV: begin
				if (div_st.done) state_d = aimd_pkg::ST_METRIC;
			end
			aimd_pkg::ST_METRIC: state_d = aimd_pkg::ST_DECIDE;
			aimd_pkg::ST_DECIDE: begin
				if (slot_free) state_d = aimd_pkg::ST_IDLE;
			end
			default: state_d = aimd_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample.ready = 1'b0;
		div_start    = 1'b0;
		commit       = 1'b0;
		case (state_q)
			aimd_pkg::ST_IDLE:   sample.ready = 1'b1;
			aimd_pkg::ST_DIV:    div_start    = !div_st.busy && !div_st.done && !first_q;
			aimd_pkg::ST_DECIDE: commit       = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= aimd_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= 16'd2918;
			beta_low_q  <= -32'sd13304;
			beta_high_q <= 32'sd30671;
			gamma_q     <= 16'd21955;
			floor_q     <= 16'd0;
			ceiling_q   <= 16'd200;
		end else if (cfg_we) begin
			case (cfg_index)
				aimd_pkg::REG_CAPACITY:  capacity_q  <= cfg_data[15:0];
				aimd_pkg::REG_BETA_LOW:  beta_low_q  <= $signed(cfg_data);
				aimd_pkg::REG_BETA_HIGH: beta_high_q <= $signed(cfg_data);
				aimd_pkg::REG_GAMMA:     gamma_q     <= cfg_data[15:0];
				aimd_pkg::REG_FLOOR:     floor_q     <= cfg_data[15:0];
				aimd_pkg::REG_CEILING:   ceiling_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// difference term: Q8.8 times Q1.15, floor shift by 7 to Q16.16
	assign diff = $signed({1'b0, lvl_q}) - $signed({1'b0, prev_q});
	assign term = aimd_pkg::MET_W'(prod_q >>> 7);

	// the metric cannot reach the 32-bit limits, so no saturation is needed
	assign metric_ext = 32'(metric_q);

	// working registers: level latch, product while the divider runs, metric and gamma flag
	always_ff @(posedge clk) begin
		if (accept) lvl_q <= lvl_clamped;
		if (state_q == aimd_pkg::ST_DIV) prod_q <= $signed({1'b0, capacity_q}) * diff;
		if (state_q == aimd_pkg::ST_METRIC) begin
			metric_q <= term - $signed({2'b00, recip}) + $signed(aimd_pkg::ONE_Q16);
			inf_q    <= lvl_q >= gamma_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b0;
		else if (accept) first_q <= !has_prev_q;
	end

	// rate update: halve, hold, or increment with ceiling and width caps, then floor
	always_comb begin
		rc        = CW'(rate_q);
		r_inc     = rc + 1'b1;
		if (r_inc > CW'(ceiling_q)) r_inc = CW'(ceiling_q);
		if (r_inc > RATE_MAX) r_inc = RATE_MAX;
		if (!inf_q && (metric_ext < beta_low_q)) begin
			mode_next = aimd_pkg::MODE_DECREASE;
			r_next    = rc >> 1;
		end else if (inf_q || (metric_ext > beta_high_q)) begin
			mode_next = aimd_pkg::MODE_INCREASE;
			r_next    = r_inc;
		end else begin
			mode_next = aimd_pkg::MODE_HOLD;
			r_next    = rc;
		end
		r_fin = r_next;
		if (r_next < CW'(floor_q)) begin
			r_fin = (CW'(floor_q) > RATE_MAX) ? RATE_MAX : CW'(floor_q);
		end
	end

	// block state advances when the result word is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= 16'd0;
			has_prev_q <= 1'b0;
			mode_q     <= aimd_pkg::MODE_HOLD;
			rate_q     <= RATE_WIDTH'(1);
		end else if (commit) begin
			prev_q     <= lvl_q;
			has_prev_q <= 1'b1;
			if (!first_q) begin
				mode_q <= mode_next;
				rate_q <= r_fin[RATE_WIDTH-1:0];
			end
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (commit) res_valid_q <= 1'b1;
		else if (result.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_rate_q <= first_q ? rc[15:0] : r_fin[15:0];
			res_mode_q <= first_q ? mode_q : mode_next;
		end
	end

	assign result.valid = res_valid_q;
	assign result.rate  = res_rate_q;
	assign result.mode  = res_mode_q;

endmodule

>>> design/aimd_checker.sv
module aimd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_valid,
	input logic        s_ready,
	input logic        r_valid,
	input logic        r_ready,
	input logic [15:0] r_rate,
	input logic [1:0]  r_mode
);

	// a word on offer stays until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result word dropped before it was taken");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> $stable(r_rate) && $stable(r_mode))
		else $error("stalled result word changed");

	// the block goes busy once a level is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready |=> !s_ready)
		else $error("level taken while the previous one is still in work");

	// a new result appears only at the end of a level's work
	a_res_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(r_valid) |-> $past(!s_ready))
		else $error("result word without a level in work");

endmodule

bind aimd_sampling_rate_fsm_top aimd_checker u_aimd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (sample.valid),
	.s_ready (sample.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_rate  (result.rate),
	.r_mode  (result.mode)
);
